// ===== rtl/core/mcdsd_pkg.sv =====
// Shared types and constants for the multichannel delta sample decoder.
// No dependencies.
package mcdsd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int CHAN_W    = 7;
    localparam int ROW_W     = 8;
    localparam int BITS_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [ROW_W-1:0]  CHANNELS_RESET = 8'd128;
    localparam logic [ROW_W-1:0]  ROWS_RESET     = 8'd40;
    localparam logic [BITS_W-1:0] BITS_RESET     = 5'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_BLOCK_ROWS    = 2'd1,
        REG_SAMPLE_BITS   = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_reg_t;

    // decoded item handed from the sequencer to the datapath
    typedef struct packed {
        logic                       is_base;
        logic signed [SAMPLE_W-1:0] base_sample;
        logic [BYTE_W-1:0]          delta;
        logic [CHAN_W-1:0]          channel;
        logic [ROW_W-1:0]           row;
        logic                       eor;
        logic                       eob;
    } item_t;

    function automatic logic [SAMPLE_W-1:0] zero_level(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0]   b;
        logic [SAMPLE_W-1:0] zl;
        b  = (bits == '0) ? BITS_W'(1) : bits;
        zl = '0;
        if (b <= BITS_W'(SAMPLE_W))
        begin
            zl = SAMPLE_W'(1) << (b - BITS_W'(1));
        end
        return zl;
    endfunction

endpackage

// ===== rtl/core/mcdsd_ctrl.sv =====
// Configuration registers, channel/row counters and base-word assembly.
// Depends on mcdsd_pkg.
module mcdsd_ctrl #(
    parameter int MAX_CHANNELS = 128,
    parameter int AW           = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic [mcdsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcdsd_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                               accept,
    input  logic [mcdsd_pkg::BYTE_W-1:0]       data_byte,
    output logic                               fire,
    output mcdsd_pkg::item_t                   item,
    output logic [AW-1:0]                      addr
);
    import mcdsd_pkg::*;

    localparam int EW = ($clog2(MAX_CHANNELS + 1) > 9) ? $clog2(MAX_CHANNELS + 1) : 9;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_CHANNELS);

    logic [ROW_W-1:0]  channels_reg;
    logic [ROW_W-1:0]  rows_reg;
    logic [BITS_W-1:0] bits_reg;
    logic [AW-1:0]     chan_reg, chan_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              pending_reg, pending_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;

    logic [EW-1:0]       eff_ch, last_ch;
    logic [ROW_W-1:0]    last_row;
    logic                eor, eob, low_byte;
    logic [AW+CHAN_W-1:0] chan_wide;

    always_comb
    begin
        if (channels_reg == '0)
        begin
            eff_ch = EW'(1);
        end
        else if (EW'(channels_reg) > MAX_E)
        begin
            eff_ch = MAX_E;
        end
        else
        begin
            eff_ch = EW'(channels_reg);
        end
        last_ch  = eff_ch - EW'(1);
        last_row = (rows_reg == '0) ? '0 : rows_reg - ROW_W'(1);
        eor      = EW'(chan_reg) >= last_ch;
        eob      = eor && (row_reg >= last_row);
        low_byte = (row_reg == '0) && !pending_reg;
        chan_wide = {{CHAN_W{1'b0}}, chan_reg};

        item.is_base     = (row_reg == '0);
        item.base_sample = {data_byte, hold_reg} - zero_level(bits_reg);
        item.delta       = data_byte;
        item.channel     = chan_wide[CHAN_W-1:0];
        item.row         = row_reg;
        item.eor         = eor;
        item.eob         = eob;
        addr             = chan_reg;
        fire             = accept && !low_byte;

        chan_next    = chan_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        hold_next    = hold_reg;
        if (accept)
        begin
            if (low_byte)
            begin
                hold_next    = data_byte;
                pending_next = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
                if (eor)
                begin
                    chan_next = '0;
                    row_next  = eob ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    chan_next = chan_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= CHANNELS_RESET;
            rows_reg     <= ROWS_RESET;
            bits_reg     <= BITS_RESET;
            chan_reg     <= '0;
            row_reg      <= '0;
            pending_reg  <= 1'b0;
            hold_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_CHANNEL_COUNT: channels_reg <= cfg_data;
                    REG_BLOCK_ROWS:    rows_reg     <= cfg_data;
                    REG_SAMPLE_BITS:   bits_reg     <= cfg_data[BITS_W-1:0];
                    REG_UNUSED:        ;
                    default:           ;
                endcase
            end
            chan_reg    <= chan_next;
            row_reg     <= row_next;
            pending_reg <= pending_next;
            hold_reg    <= hold_next;
        end
    end

    a_pending_base_row: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> row_reg == '0)
        else $error("high byte pending outside base row");

    a_block_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.eob |=> row_reg == '0 && chan_reg == '0 && !pending_reg)
        else $error("counters not wrapped after end of block");

endmodule

// ===== rtl/core/mcdsd_dp.sv =====
// Sample store, delta add with write bypass, and the output register.
// Depends on mcdsd_pkg.
module mcdsd_dp #(
    parameter int MAX_CHANNELS = 128,
    parameter int AW           = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  mcdsd_pkg::item_t                     item,
    input  logic [AW-1:0]                        addr,
    input  logic                                 out_stall,
    output logic                                 busy,
    output logic                                 out_valid,
    output logic signed [mcdsd_pkg::SAMPLE_W-1:0] sample_value,
    output logic [mcdsd_pkg::CHAN_W-1:0]         channel_index,
    output logic [mcdsd_pkg::ROW_W-1:0]          row_index,
    output logic                                 end_of_row,
    output logic                                 end_of_block
);
    import mcdsd_pkg::*;

    logic [SAMPLE_W-1:0] mem [MAX_CHANNELS];

    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [SAMPLE_W-1:0] rd_reg;
    logic                hit_reg;
    logic [SAMPLE_W-1:0] byp_reg;

    logic                out_valid_reg;
    item_t               out_item_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;

    logic                s1_move;
    logic [SAMPLE_W-1:0] prev, sample;

    always_comb
    begin
        s1_move = s1_valid_reg && (!out_valid_reg || !out_stall);
        busy    = s1_valid_reg && !s1_move;
        prev    = hit_reg ? byp_reg : rd_reg;
        sample  = s1_item_reg.is_base ? s1_item_reg.base_sample
                : prev + {{(SAMPLE_W-BYTE_W){s1_item_reg.delta[BYTE_W-1]}}, s1_item_reg.delta};
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            mem[s1_addr_reg] <= sample;
        end
        if (fire)
        begin
            rd_reg      <= mem[addr];
            hit_reg     <= s1_move && (s1_addr_reg == addr);
            byp_reg     <= sample;
            s1_item_reg <= item;
            s1_addr_reg <= addr;
        end
        if (s1_move)
        begin
            out_item_reg   <= s1_item_reg;
            out_sample_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_value  = out_sample_reg;
    assign channel_index = out_item_reg.channel;
    assign row_index     = out_item_reg.row;
    assign end_of_row    = out_item_reg.eor;
    assign end_of_block  = out_item_reg.eob;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !busy)
        else $error("item taken while stage one is blocked");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stage one lost or changed while output stalled");

    a_eob_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.eob |-> out_item_reg.eor)
        else $error("end of block without end of row");

endmodule

// ===== rtl/core/multichannel_delta_sample_decoder.sv =====
// Top level of the multichannel delta sample decoder.
// Depends on mcdsd_pkg, mcdsd_ctrl and mcdsd_dp.
//
// Input channel (in_valid/in_stall/data_byte) takes one raw stream byte per
// cycle while in_stall is low. Each block starts with a base row of
// little-endian 16-bit words, one per channel, then block_rows-1 rows of
// signed 8-bit deltas. Output channel (out_valid/out_stall) gives one
// sample per completed word or delta byte, tagged with channel, row and
// end-of-row/end-of-block. The byte completing a result is registered in
// stage one, then in the output register. Throughput: one byte per cycle
// when not stalled, set by the single read and single write port of the
// per-channel sample store (base-row words give one result per two bytes).
// Receiver stall: up to two results are buffered (stage one and output
// register); beyond that in_stall rises the same cycle.
// Configuration (cfg_valid/cfg_ready) is always ready; write only while idle.
// Reset clears counters and restores default registers (128 channels, 40
// rows, 12 bits); the sample store is not cleared, each channel is loaded by
// its base-row word before any delta reads it.
module multichannel_delta_sample_decoder #(
    parameter int MAX_CHANNELS = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mcdsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcdsd_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mcdsd_pkg::BYTE_W-1:0]          data_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mcdsd_pkg::SAMPLE_W-1:0] sample_value,
    output logic [mcdsd_pkg::CHAN_W-1:0]          channel_index,
    output logic [mcdsd_pkg::ROW_W-1:0]           row_index,
    output logic                                  end_of_row,
    output logic                                  end_of_block
);
    import mcdsd_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic          busy;
    logic          accept;
    logic          fire;
    item_t         item;
    logic [AW-1:0] addr;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign accept    = in_valid && !busy;

    mcdsd_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .fire      (fire),
        .item      (item),
        .addr      (addr)
    );

    mcdsd_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (item),
        .addr          (addr),
        .out_stall     (out_stall),
        .busy          (busy),
        .out_valid     (out_valid),
        .sample_value  (sample_value),
        .channel_index (channel_index),
        .row_index     (row_index),
        .end_of_row    (end_of_row),
        .end_of_block  (end_of_block)
    );

endmodule
